// ===== rtl/amu_pkg.sv =====
package amu_pkg;

   localparam logic [1:0] MODE_UPDATE = 2'd0;
   localparam logic [1:0] MODE_LOAD   = 2'd1;
   localparam logic [1:0] MODE_SEED   = 2'd2;

   localparam logic [1:0] CSR_TIME_STEP        = 2'd0;
   localparam logic [1:0] CSR_EARTH_RATE_NORTH = 2'd1;
   localparam logic [1:0] CSR_EARTH_RATE_UP    = 2'd2;

   localparam logic [31:0] TIME_STEP_RESET = 32'd87960930;

   typedef struct packed {
      logic [1:0]         mode;
      logic [1:0]         row_index;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
   } amu_req_type;

   typedef struct packed {
      logic signed [31:0] m00;
      logic signed [31:0] m01;
      logic signed [31:0] m02;
      logic signed [31:0] m10;
      logic signed [31:0] m11;
      logic signed [31:0] m12;
      logic signed [31:0] m20;
      logic signed [31:0] m21;
      logic signed [31:0] m22;
      logic               degenerate_row;
   } amu_rsp_type;

endpackage

// ===== rtl/amu_if.sv =====
interface amu_req_if import amu_pkg::*; ();
   logic        valid;
   logic        ready;
   amu_req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface amu_rsp_if import amu_pkg::*; ();
   logic        valid;
   logic        ready;
   amu_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/amu_ram.sv =====
module amu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 9
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/attitude_matrix_update_core.sv =====
// channel  | direction | payload
// req_ch   | in        | mode, row_index, vec_x, vec_y, vec_z
// rsp_ch   | out       | m00 .. m22, degenerate_row
// csr_*    | in        | time_step, earth_rate_north, earth_rate_up
//
// One transaction at a time. Load and seed read the matrix and previous
// vector memories, dispatch, then write back. Update is paced by the
// shared multiplier and by the one-bit-per-cycle square root (32 steps)
// and divider (31 steps per element).
// Reset clears valid bits; unwritten entries read as identity or zero.
// A new request is taken while the previous response waits in its register.
module attitude_matrix_update_core import amu_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   amu_req_if.sink     req_ch,
   amu_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wr_data
);

   localparam int WK = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
   localparam int MA = WK + 3;
   localparam int MB = 33;
   localparam int PW = MA + MB;
   localparam logic signed [WK-1:0] ONE_Q30 = {{(WK-31){1'b0}}, 1'b1, 30'b0};

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RD   = 4'd1;
   localparam logic [3:0] ST_DISP = 4'd2;
   localparam logic [3:0] ST_DV   = 4'd3;
   localparam logic [3:0] ST_TS   = 4'd4;
   localparam logic [3:0] ST_SQ   = 4'd5;
   localparam logic [3:0] ST_RT   = 4'd6;
   localparam logic [3:0] ST_LEN  = 4'd7;
   localparam logic [3:0] ST_DIV  = 4'd8;
   localparam logic [3:0] ST_WB   = 4'd9;
   localparam logic [3:0] ST_OUT  = 4'd10;

   function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] x);
      logic signed [PW-1:0] hi;
      logic signed [PW-1:0] lo;
      hi = PW'({31{1'b1}});
      lo = ~hi;
      if (x > hi) return hi[31:0];
      else if (x < lo) return lo[31:0];
      else return x[31:0];
   endfunction

   function automatic logic signed [WK-1:0] satw(input logic signed [PW-1:0] x);
      logic signed [PW-1:0] hi;
      logic signed [PW-1:0] lo;
      hi = PW'({(DATA_WIDTH-1){1'b1}});
      lo = ~hi;
      if (x > hi) return hi[WK-1:0];
      else if (x < lo) return lo[WK-1:0];
      else return x[WK-1:0];
   endfunction

   function automatic logic [3:0] eidx(input logic [1:0] r, input logic [1:0] c);
      return {1'b0, r, 1'b0} + {2'b0, r} + {2'b0, c};
   endfunction

   function automatic logic [1:0] nxt(input logic [1:0] r);
      return (r == 2'd2) ? 2'd0 : r + 2'd1;
   endfunction

   function automatic logic [1:0] prv(input logic [1:0] r);
      return (r == 2'd0) ? 2'd2 : r - 2'd1;
   endfunction

   logic [3:0]  state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [1:0]  row_ff, row_in;
   logic [1:0]  col_ff, col_in;
   logic [2:0]  sub_ff, sub_in;
   logic [4:0]  it_ff, it_in;
   logic [8:0]  mvalid_ff, mvalid_in;
   logic [2:0]  pvalid_ff, pvalid_in;
   logic        degen_ff, degen_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] time_step_ff;
   logic signed [31:0] earth_north_ff;
   logic signed [31:0] earth_up_ff;

   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  row_idx_ff, row_idx_in;
   logic signed [WK-1:0] v_ff [3];
   logic signed [WK-1:0] v_in [3];
   logic signed [WK-1:0] pv_ff [3];
   logic signed [WK-1:0] pv_in [3];
   logic signed [WK-1:0] wk_ff [9];
   logic signed [WK-1:0] wk_in [9];
   logic signed [31:0]   na_ff [9];
   logic signed [31:0]   na_in [9];
   logic signed [31:0]   d_ff [3];
   logic signed [31:0]   d_in [3];
   logic signed [MA-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [MA-1:0] mul_a;
   logic signed [MB-1:0] mul_b;
   logic [63:0] sqv_ff, sqv_in;
   logic [63:0] sqr_ff, sqr_in;
   logic [31:0] rem_ff, rem_in;
   logic [30:0] sh_ff, sh_in;
   logic [30:0] q_ff, q_in;
   amu_rsp_type rsp_data_ff, rsp_data_in;

   logic        row_done;
   logic [3:0]  rd_idx;
   logic [63:0] bitv;
   logic [63:0] trial;
   logic signed [31:0] elem;
   logic [31:0] mag;
   logic [32:0] rem2;
   logic        ge;
   logic signed [PW-1:0] qv;
   logic signed [PW-1:0] avg;

   logic          mat_we, prev_we;
   logic [3:0]    mat_waddr, mat_raddr;
   logic [1:0]    prev_waddr, prev_raddr;
   logic [WK-1:0] mat_wdata, mat_rdata, prev_wdata, prev_rdata;

   amu_ram #(.WIDTH(WK), .DEPTH(9)) u_mat_ram (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr (mat_waddr),
      .wr_data (mat_wdata),
      .rd_addr (mat_raddr),
      .rd_data (mat_rdata)
   );

   amu_ram #(.WIDTH(WK), .DEPTH(3)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_addr (prev_raddr),
      .rd_data (prev_rdata)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;
   assign prod_in      = PW'(mul_a) * PW'(mul_b);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      sub_in      = sub_ff;
      it_in       = it_ff;
      mvalid_in   = mvalid_ff;
      pvalid_in   = pvalid_ff;
      degen_in    = degen_ff;
      mode_in     = mode_ff;
      row_idx_in  = row_idx_ff;
      v_in        = v_ff;
      pv_in       = pv_ff;
      wk_in       = wk_ff;
      na_in       = na_ff;
      d_in        = d_ff;
      acc_in      = acc_ff;
      sqv_in      = sqv_ff;
      sqr_in      = sqr_ff;
      rem_in      = rem_ff;
      sh_in       = sh_ff;
      q_in        = q_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      mul_a       = '0;
      mul_b       = '0;
      row_done    = 1'b0;
      rd_idx      = cnt_ff - 4'd1;
      bitv        = 64'd1 << {it_ff, 1'b0};
      trial       = sqr_ff + bitv;
      elem        = na_ff[eidx(row_ff, col_ff)];
      mag         = elem[31] ? (~elem + 32'd1) : elem;
      rem2        = {rem_ff, sh_ff[30]};
      ge          = (rem2 >= {1'b0, sqr_ff[31:0]});
      qv          = PW'({ q_ff[29:0], ge });
      avg         = (PW'(v_ff[row_ff]) + PW'(pv_ff[row_ff])) >>> 1;
      mat_we      = 1'b0;
      mat_waddr   = cnt_ff;
      mat_wdata   = wk_ff[cnt_ff];
      mat_raddr   = (cnt_ff < 4'd9) ? cnt_ff : 4'd0;
      prev_we     = 1'b0;
      prev_waddr  = cnt_ff[1:0];
      prev_wdata  = pv_ff[cnt_ff[1:0]];
      prev_raddr  = (cnt_ff < 4'd3) ? cnt_ff[1:0] : 2'd0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               mode_in    = req_ch.data.mode;
               row_idx_in = req_ch.data.row_index;
               v_in[0]    = satw(PW'(req_ch.data.vec_x));
               v_in[1]    = satw(PW'(req_ch.data.vec_y));
               v_in[2]    = satw(PW'(req_ch.data.vec_z));
               degen_in   = 1'b0;
               cnt_in     = 4'd0;
               state_in   = ST_RD;
            end
         end
         ST_RD: begin
            if (cnt_ff != 4'd0) begin
               wk_in[rd_idx] = mvalid_ff[rd_idx] ? mat_rdata :
                  ((rd_idx == 4'd0 || rd_idx == 4'd4 || rd_idx == 4'd8) ? ONE_Q30 : '0);
               if (cnt_ff < 4'd4) begin
                  pv_in[rd_idx[1:0]] = pvalid_ff[rd_idx[1:0]] ? prev_rdata : '0;
               end
            end
            if (cnt_ff == 4'd9) begin
               state_in = ST_DISP;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_DISP: begin
            cnt_in = 4'd0;
            row_in = 2'd0;
            col_in = 2'd0;
            sub_in = 3'd0;
            state_in = ST_WB;
            unique case (mode_ff)
               MODE_UPDATE: state_in = ST_DV;
               MODE_LOAD: begin
                  if (row_idx_ff != 2'd3) begin
                     for (int k = 0; k < 3; k++) begin
                        wk_in[eidx(row_idx_ff, 2'(k))] = v_ff[k];
                     end
                  end
               end
               MODE_SEED: pv_in = v_ff;
               default: ;
            endcase
         end
         ST_DV: begin
            unique case (sub_ff)
               3'd0: begin
                  mul_a  = MA'(wk_ff[eidx(row_ff, 2'd1)]);
                  mul_b  = MB'(earth_north_ff);
                  sub_in = 3'd1;
               end
               3'd1: begin
                  mul_a  = MA'(wk_ff[eidx(row_ff, 2'd2)]);
                  mul_b  = MB'(earth_up_ff);
                  acc_in = MA'(prod_ff >>> 30);
                  sub_in = 3'd2;
               end
               3'd2: begin
                  acc_in = acc_ff + MA'(prod_ff >>> 30);
                  sub_in = 3'd3;
               end
               default: begin
                  d_in[row_ff] = sat32(avg - PW'(acc_ff));
                  sub_in = 3'd0;
                  if (row_ff == 2'd2) begin
                     row_in   = 2'd0;
                     col_in   = 2'd0;
                     state_in = ST_TS;
                  end else begin
                     row_in = row_ff + 2'd1;
                  end
               end
            endcase
         end
         ST_TS: begin
            unique case (sub_ff)
               3'd0: begin
                  mul_a  = MA'(wk_ff[eidx(nxt(row_ff), col_ff)]);
                  mul_b  = MB'(d_ff[prv(row_ff)]);
                  sub_in = 3'd1;
               end
               3'd1: begin
                  mul_a  = MA'(wk_ff[eidx(prv(row_ff), col_ff)]);
                  mul_b  = MB'(d_ff[nxt(row_ff)]);
                  acc_in = MA'(prod_ff >>> 30);
                  sub_in = 3'd2;
               end
               3'd2: begin
                  acc_in = acc_ff - MA'(prod_ff >>> 30);
                  sub_in = 3'd3;
               end
               3'd3: begin
                  mul_a  = acc_ff;
                  mul_b  = {5'b0, time_step_ff[31:4]};
                  sub_in = 3'd4;
               end
               default: begin
                  na_in[eidx(row_ff, col_ff)] =
                     sat32(PW'(wk_ff[eidx(row_ff, col_ff)]) + (prod_ff >>> 26));
                  sub_in = 3'd0;
                  if (col_ff == 2'd2) begin
                     col_in = 2'd0;
                     if (row_ff == 2'd2) begin
                        row_in   = 2'd0;
                        state_in = ST_SQ;
                     end else begin
                        row_in = row_ff + 2'd1;
                     end
                  end else begin
                     col_in = col_ff + 2'd1;
                  end
               end
            endcase
         end
         ST_SQ: begin
            unique case (sub_ff)
               3'd0: begin
                  mul_a  = MA'(na_ff[eidx(row_ff, 2'd0)]);
                  mul_b  = MB'(na_ff[eidx(row_ff, 2'd0)]);
                  sub_in = 3'd1;
               end
               3'd1: begin
                  mul_a  = MA'(na_ff[eidx(row_ff, 2'd1)]);
                  mul_b  = MB'(na_ff[eidx(row_ff, 2'd1)]);
                  sqv_in = prod_ff[63:0];
                  sub_in = 3'd2;
               end
               3'd2: begin
                  mul_a  = MA'(na_ff[eidx(row_ff, 2'd2)]);
                  mul_b  = MB'(na_ff[eidx(row_ff, 2'd2)]);
                  sqv_in = sqv_ff + prod_ff[63:0];
                  sub_in = 3'd3;
               end
               default: begin
                  sqv_in   = sqv_ff + prod_ff[63:0];
                  sqr_in   = 64'd0;
                  it_in    = 5'd31;
                  sub_in   = 3'd0;
                  state_in = ST_RT;
               end
            endcase
         end
         ST_RT: begin
            if (sqv_ff >= trial) begin
               sqv_in = sqv_ff - trial;
               sqr_in = (sqr_ff >> 1) + bitv;
            end else begin
               sqr_in = sqr_ff >> 1;
            end
            it_in = it_ff - 5'd1;
            if (it_ff == 5'd0) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (sqr_ff == 64'd0) begin
               degen_in = 1'b1;
               row_done = 1'b1;
            end else begin
               col_in   = 2'd0;
               sub_in   = 3'd0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sub_ff == 3'd0) begin
               rem_in = {1'b0, mag[31:1]};
               sh_in  = {mag[0], 30'b0};
               q_in   = '0;
               it_in  = 5'd30;
               sub_in = 3'd1;
            end else begin
               rem_in = ge ? 32'(rem2 - {1'b0, sqr_ff[31:0]}) : rem2[31:0];
               q_in   = {q_ff[29:0], ge};
               sh_in  = sh_ff << 1;
               it_in  = it_ff - 5'd1;
               if (it_ff == 5'd0) begin
                  wk_in[eidx(row_ff, col_ff)] = satw(elem[31] ? -qv : qv);
                  sub_in = 3'd0;
                  if (col_ff == 2'd2) begin
                     row_done = 1'b1;
                  end else begin
                     col_in = col_ff + 2'd1;
                  end
               end
            end
         end
         ST_WB: begin
            mat_we = 1'b1;
            mvalid_in[cnt_ff] = 1'b1;
            if (cnt_ff < 4'd3) begin
               prev_we = 1'b1;
               pvalid_in[cnt_ff[1:0]] = 1'b1;
            end
            if (cnt_ff == 4'd8) begin
               state_in = ST_OUT;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.m00 = sat32(PW'(wk_ff[0]));
               rsp_data_in.m01 = sat32(PW'(wk_ff[1]));
               rsp_data_in.m02 = sat32(PW'(wk_ff[2]));
               rsp_data_in.m10 = sat32(PW'(wk_ff[3]));
               rsp_data_in.m11 = sat32(PW'(wk_ff[4]));
               rsp_data_in.m12 = sat32(PW'(wk_ff[5]));
               rsp_data_in.m20 = sat32(PW'(wk_ff[6]));
               rsp_data_in.m21 = sat32(PW'(wk_ff[7]));
               rsp_data_in.m22 = sat32(PW'(wk_ff[8]));
               rsp_data_in.degenerate_row = degen_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (row_done) begin
         sub_in = 3'd0;
         if (row_ff == 2'd2) begin
            pv_in    = v_ff;
            cnt_in   = 4'd0;
            state_in = ST_WB;
         end else begin
            row_in   = row_ff + 2'd1;
            state_in = ST_SQ;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         row_ff         <= '0;
         col_ff         <= '0;
         sub_ff         <= '0;
         it_ff          <= '0;
         mvalid_ff      <= '0;
         pvalid_ff      <= '0;
         degen_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         time_step_ff   <= TIME_STEP_RESET;
         earth_north_ff <= '0;
         earth_up_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         sub_ff       <= sub_in;
         it_ff        <= it_in;
         mvalid_ff    <= mvalid_in;
         pvalid_ff    <= pvalid_in;
         degen_ff     <= degen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_TIME_STEP:        time_step_ff   <= csr_wr_data;
               CSR_EARTH_RATE_NORTH: earth_north_ff <= csr_wr_data;
               CSR_EARTH_RATE_UP:    earth_up_ff    <= csr_wr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      row_idx_ff  <= row_idx_in;
      v_ff        <= v_in;
      pv_ff       <= pv_in;
      wk_ff       <= wk_in;
      na_ff       <= na_in;
      d_ff        <= d_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      sqv_ff      <= sqv_in;
      sqr_ff      <= sqr_in;
      rem_ff      <= rem_in;
      sh_ff       <= sh_in;
      q_ff        <= q_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_accept_starts_read: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_RD))
      else $error("accepted transaction did not start the memory read");

   a_valid_kept: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((mvalid_ff & $past(mvalid_ff)) == $past(mvalid_ff)))
      else $error("matrix valid bit cleared outside reset");

   a_out_all_written: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (mvalid_ff == '1 && pvalid_ff == '1))
      else $error("response issued before full write-back");

   a_degen_update_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && degen_ff) |-> (mode_ff == MODE_UPDATE))
      else $error("degenerate flag outside update");

endmodule
